### rtl/core/btc_pkg.sv
// Shared constants and types for the block transposition cipher.
// No dependencies; used by all rtl/core files but btc_stream_if.
package btc_pkg;

  localparam int MAX_BLOCK = 16;
  localparam int IDX_W     = 4;   // one nibble of the permutation table
  localparam int LEN_W     = 5;   // holds 0..MAX_BLOCK
  localparam int BANKS     = 2;   // double-buffered block store
  localparam int ADDR_W    = 5;   // bank bit plus byte index

  localparam logic [7:0]       PAD_BYTE        = 8'h58;  // 'X'
  localparam logic [LEN_W-1:0] RESET_BLOCK_LEN = 5'd16;
  localparam logic [63:0]      RESET_PERM      = 64'hFEDC_BA98_7654_3210;

  // configuration register indexes
  localparam logic REG_BLOCK_LEN  = 1'b0;
  localparam logic REG_PERM_TABLE = 1'b1;

  // one completed block handed from front to back
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] count;  // bytes actually stored
    logic [LEN_W-1:0] len;    // effective block length
    logic             last;   // block closes the message
  } desc_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } buf_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } release_t;

endpackage

### rtl/core/btc_stream_if.sv
// Valid/ready stream interfaces for plaintext input and cipher output.
// No dependencies.
interface btc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       msg_last;

  modport source (output valid, output data_byte, output msg_last, input ready);
  modport sink   (input valid, input data_byte, input msg_last, output ready);
endinterface

interface btc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;
  logic       out_last;

  modport source (output valid, output cipher_byte, output out_last, input ready);
  modport sink   (input valid, input cipher_byte, input out_last, output ready);
endinterface

### rtl/core/btc_queue.sv
// Two-entry queue of block descriptors between front and back.
// Depends on btc_pkg.
module btc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  btc_pkg::desc_t push_desc,
  input  logic           pop,
  output logic           head_valid,
  output btc_pkg::desc_t head_desc
);

  btc_pkg::desc_t slots [btc_pkg::BANKS];
  logic           rptr;
  logic           wptr;
  logic [1:0]     count;

  assign head_valid = (count != 2'd0);
  assign head_desc  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rptr  <= 1'b0;
      wptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### rtl/core/btc_front.sv
// Front end: accepts plaintext bytes, fills the current bank and closes
// blocks into descriptors. Depends on btc_pkg and btc_stream_if.
module btc_front (
  input  logic                           clk,
  input  logic                           rst,
  btc_in_if.sink                         plain_ch,
  input  logic [btc_pkg::LEN_W-1:0]      block_len,
  input  btc_pkg::release_t              rel,
  output btc_pkg::buf_wr_t               buf_wr,
  output logic                           desc_push,
  output btc_pkg::desc_t                 desc
);

  logic [btc_pkg::LEN_W-1:0] fill;
  logic [btc_pkg::LEN_W-1:0] fill_inc;
  logic [btc_pkg::LEN_W-1:0] eff_len;
  logic                      wbank;
  logic [btc_pkg::BANKS-1:0] busy;
  logic [btc_pkg::BANKS-1:0] busy_next;
  logic                      accept;
  logic                      done;

  always_comb begin
    if (block_len == '0) begin
      eff_len = btc_pkg::LEN_W'(1);
    end else if (block_len > btc_pkg::LEN_W'(btc_pkg::MAX_BLOCK)) begin
      eff_len = btc_pkg::LEN_W'(btc_pkg::MAX_BLOCK);
    end else begin
      eff_len = block_len;
    end
  end

  // a bank still being emitted by the back end cannot be refilled
  assign plain_ch.ready = !busy[wbank];
  assign accept         = plain_ch.valid && plain_ch.ready;
  assign fill_inc       = fill + btc_pkg::LEN_W'(1);
  assign done           = (fill_inc >= eff_len) || plain_ch.msg_last;

  // fill can pass the length only after a mid-block length change
  assign buf_wr.en   = accept && (fill < btc_pkg::LEN_W'(btc_pkg::MAX_BLOCK));
  assign buf_wr.addr = {wbank, fill[btc_pkg::IDX_W-1:0]};
  assign buf_wr.data = plain_ch.data_byte;

  assign desc_push  = accept && done;
  assign desc.bank  = wbank;
  assign desc.count = fill_inc;
  assign desc.len   = eff_len;
  assign desc.last  = plain_ch.msg_last;

  always_comb begin
    busy_next = busy;
    if (rel.en) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (desc_push) begin
      busy_next[wbank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      wbank <= 1'b0;
      busy  <= '0;
    end else begin
      busy <= busy_next;
      if (accept) begin
        if (done) begin
          fill  <= '0;
          wbank <= ~wbank;
        end else begin
          fill <= fill_inc;
        end
      end
    end
  end

endmodule

### rtl/core/btc_back.sv
// Back end: holds the two-bank block store and emits each block in
// permuted order, one byte per cycle unless the output stalls. Depends on btc_pkg and btc_stream_if.
module btc_back (
  input  logic                           clk,
  input  logic                           rst,
  input  btc_pkg::buf_wr_t               buf_wr,
  input  logic [63:0]                    perm_table,
  input  logic                           q_valid,
  input  btc_pkg::desc_t                 q_desc,
  output logic                           q_pop,
  output btc_pkg::release_t              rel,
  btc_out_if.source                      cipher_ch
);

  logic [7:0] store [btc_pkg::BANKS * btc_pkg::MAX_BLOCK];

  btc_pkg::desc_t            cur;
  logic                      active;
  logic [btc_pkg::IDX_W-1:0] pos;
  logic [btc_pkg::IDX_W-1:0] src;
  logic                      advance;
  logic                      end_blk;
  logic                      take_src;
  logic                      out_valid;
  logic [7:0]                out_byte;
  logic                      out_last;

  assign src      = perm_table[{pos, 2'b00} +: btc_pkg::IDX_W];
  assign advance  = active && (!out_valid || cipher_ch.ready);
  assign end_blk  = ({1'b0, pos} == (cur.len - btc_pkg::LEN_W'(1)));
  // sources past the stored bytes or past the length read as padding
  assign take_src = ({1'b0, src} < cur.len) && ({1'b0, src} < cur.count);

  // next block is picked up in the cycle the current one finishes
  assign q_pop    = q_valid && (!active || (advance && end_blk));
  assign rel.en   = advance && end_blk;
  assign rel.bank = cur.bank;

  assign cipher_ch.valid       = out_valid;
  assign cipher_ch.cipher_byte = out_byte;
  assign cipher_ch.out_last    = out_last;

  always_ff @(posedge clk) begin
    if (buf_wr.en) begin
      store[buf_wr.addr] <= buf_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= take_src ? store[{cur.bank, src}] : btc_pkg::PAD_BYTE;
      out_last <= cur.last && end_blk;
    end
    if (q_pop) begin
      cur <= q_desc;
      pos <= '0;
    end else if (advance) begin
      pos <= pos + btc_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        active <= 1'b1;
      end else if (advance && end_blk) begin
        active <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (cipher_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/block_transposition_cipher.sv
// Block transposition cipher: bytes in, permuted blocks out, 'X' padding.
// With the back end free, a closed block's descriptor is queued, then loaded by the back
// end, which then registers the block's first byte. Throughput: one byte per cycle within
// a block when the output is ready; steady flow stalls input while both banks are held.
// Reset: config returns to length 16 and identity table; fill, queue and output
// clear; block store contents are not cleared.
module block_transposition_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  btc_in_if.sink      plain_ch,
  btc_out_if.source   cipher_ch
);

  logic [btc_pkg::LEN_W-1:0] block_len;
  logic [63:0]               perm_table;
  btc_pkg::buf_wr_t          buf_wr;
  btc_pkg::release_t         rel;
  btc_pkg::desc_t            push_desc;
  btc_pkg::desc_t            head_desc;
  logic                      desc_push;
  logic                      head_valid;
  logic                      q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_len  <= btc_pkg::RESET_BLOCK_LEN;
      perm_table <= btc_pkg::RESET_PERM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        btc_pkg::REG_BLOCK_LEN:  block_len  <= cfg_data[btc_pkg::LEN_W-1:0];
        btc_pkg::REG_PERM_TABLE: perm_table <= cfg_data;
        default: ;
      endcase
    end
  end

  btc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .plain_ch  (plain_ch),
    .block_len (block_len),
    .rel       (rel),
    .buf_wr    (buf_wr),
    .desc_push (desc_push),
    .desc      (push_desc)
  );

  btc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (desc_push),
    .push_desc  (push_desc),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  btc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .buf_wr     (buf_wr),
    .perm_table (perm_table),
    .q_valid    (head_valid),
    .q_desc     (head_desc),
    .q_pop      (q_pop),
    .rel        (rel),
    .cipher_ch  (cipher_ch)
  );

endmodule
